// ----- rtl/core/frustum_culling_test_macros.svh -----
// assertion macros used by the checker file
`ifndef FRUSTUM_CULLING_TEST_MACROS_SVH
`define FRUSTUM_CULLING_TEST_MACROS_SVH

// clocked property, off while reset is low
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication, off while reset is low
`define FCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fct_pkg.sv -----
package fct_pkg;

    localparam int unsigned NUM_PLANES_DEF = 6;
    localparam int unsigned MAX_PLANES     = 6;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned COORD_W        = 16;
    localparam int unsigned RADIUS_W       = 15;
    localparam int unsigned FRAC_BITS      = 14;
    localparam int unsigned PROD_W         = 2 * COORD_W;
    // three products, d and margin scaled by 2^14 stay below 2^33 in magnitude
    localparam int unsigned SUM_W          = PROD_W + 3;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // one item in flight along the chain
    typedef struct packed {
        logic                              valid;
        logic                              ok;
        logic [2:0][COORD_W-1:0]           lo;     // coordinate for a non-negative normal
        logic [2:0][COORD_W-1:0]           hi;     // coordinate for a negative normal
        logic [RADIUS_W-1:0]               margin;
    } item_t;

endpackage

// ----- rtl/core/frustum_culling_test.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// item in  | start, busy           | command, ax, ay, az, bx, by, bz, radius
// result   | done (one cycle)      | inside_res
// config   | cfg_we                | cfg_index, cfg_data
//
// one item a cycle; the result passes the entry register plus two registers
// in each plane cell
// busy is never raised: each cell takes a new item every cycle
// rst_n clears the pipeline valid bits and all plane registers to zero
// the receiver cannot stall, so done is a one-cycle strobe with no hold
module frustum_culling_test
    import fct_pkg::*;
#(
    parameter int unsigned NUM_PLANES = NUM_PLANES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] ax,
    input  logic signed [COORD_W-1:0] ay,
    input  logic signed [COORD_W-1:0] az,
    input  logic signed [COORD_W-1:0] bx,
    input  logic signed [COORD_W-1:0] by,
    input  logic signed [COORD_W-1:0] bz,
    input  logic [RADIUS_W-1:0]       radius,
    output logic                      done,
    output logic                      inside_res,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // chain[0] leaves the entry stage, chain[k+1] leaves plane cell k
    item_t chain [NUM_PLANES+1];

    // no state links items, so the input is always open
    assign busy = 1'b0;

    // decode the command and order box bounds once for all planes
    fct_entry u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (start & ~busy),
        .command  (command),
        .ax       (ax),
        .ay       (ay),
        .az       (az),
        .bx       (bx),
        .by       (by),
        .bz       (bz),
        .radius   (radius),
        .item_out (chain[0])
    );

    // one cell per plane; each holds its own plane and ands in its verdict
    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_cell
        fct_cell #(
            .PLANE_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .item_in   (chain[g]),
            .item_out  (chain[g+1])
        );
    end

    // result straight from the last cell's register
    assign done       = chain[NUM_PLANES].valid;
    assign inside_res = chain[NUM_PLANES].valid & chain[NUM_PLANES].ok;

endmodule

// ----- rtl/core/fct_entry.sv -----
module fct_entry
    import fct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] ax,
    input  logic signed [COORD_W-1:0] ay,
    input  logic signed [COORD_W-1:0] az,
    input  logic signed [COORD_W-1:0] bx,
    input  logic signed [COORD_W-1:0] by,
    input  logic signed [COORD_W-1:0] bz,
    input  logic [RADIUS_W-1:0]       radius,
    output item_t                     item_out
);

    item_t item_reg;
    item_t item_next;

    logic [2:0][COORD_W-1:0] a_vec;
    logic [2:0][COORD_W-1:0] b_vec;
    logic [2:0][COORD_W-1:0] mn;
    logic [2:0][COORD_W-1:0] mx;

    assign a_vec = {az, ay, ax};
    assign b_vec = {bz, by, bx};

    // per axis order for the box: the worst corner per plane is picked later
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(a_vec[k]) <= $signed(b_vec[k]))
            begin
                mn[k] = a_vec[k];
                mx[k] = b_vec[k];
            end
            else
            begin
                mn[k] = b_vec[k];
                mx[k] = a_vec[k];
            end
        end
    end

    always_comb
    begin
        item_next.valid  = take;
        item_next.ok     = 1'b1;
        item_next.lo     = a_vec;
        item_next.hi     = a_vec;
        item_next.margin = '0;
        unique case (cmd_t'(command))
            CMD_POINT:
            begin
            end
            CMD_SPHERE:
            begin
                item_next.margin = radius;
            end
            CMD_BOX:
            begin
                item_next.lo = mn;
                item_next.hi = mx;
            end
            CMD_NONE:
            begin
                item_next.ok = 1'b0;
            end
            default:
            begin
                item_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg.valid <= 1'b0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ----- rtl/core/fct_cell.sv -----
module fct_cell
    import fct_pkg::*;
#(
    parameter int unsigned PLANE_IDX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  item_t                 item_in,
    output item_t                 item_out
);

    logic [CFG_DATA_W-1:0] plane_reg;
    logic [CFG_DATA_W-1:0] plane_next;

    item_t mid_reg;
    item_t mid_next;
    item_t out_reg;
    item_t out_next;

    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];

    logic signed [COORD_W-1:0] nrm [3];
    logic signed [COORD_W-1:0] sel [3];
    logic signed [COORD_W-1:0] plane_d;
    logic signed [SUM_W-1:0]   dist_term;
    logic signed [SUM_W-1:0]   margin_term;
    logic signed [SUM_W-1:0]   total;

    // plane: nx 15:0, ny 31:16, nz 47:32, d 63:48
    always_comb
    begin
        plane_next = plane_reg;
        if (cfg_we && (cfg_index == CFG_IDX_W'(PLANE_IDX)))
        begin
            plane_next = cfg_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrm[k] = $signed(plane_reg[k*COORD_W +: COORD_W]);
        end
    end
    assign plane_d = $signed(plane_reg[3*COORD_W +: COORD_W]);

    // stage one: worst corner per axis, then the three products
    always_comb
    begin
        mid_next = item_in;
        for (int k = 0; k < 3; k++)
        begin
            sel[k]       = nrm[k][COORD_W-1] ? $signed(item_in.hi[k]) : $signed(item_in.lo[k]);
            prod_next[k] = nrm[k] * sel[k];
        end
    end

    // stage two: distance plus margin, test the sign
    assign dist_term   = SUM_W'(plane_d) <<< FRAC_BITS;
    assign margin_term = $signed({{(SUM_W-RADIUS_W){1'b0}}, mid_reg.margin}) <<< FRAC_BITS;
    assign total       = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                         + dist_term + margin_term;

    always_comb
    begin
        out_next    = mid_reg;
        out_next.ok = mid_reg.ok & ~total[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg     <= '0;
            mid_reg.valid <= 1'b0;
            out_reg.valid <= 1'b0;
        end
        else
        begin
            plane_reg <= plane_next;
            mid_reg   <= mid_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
    end

    assign item_out = out_reg;

endmodule

// ----- rtl/core/fct_checker.sv -----
`include "frustum_culling_test_macros.svh"

module fct_checker
    import fct_pkg::*;
#(
    parameter int unsigned NUM_PLANES = NUM_PLANES_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic inside_res
);

    localparam int unsigned LATENCY = 1 + 2 * NUM_PLANES;

    // every accepted item comes out after the fixed latency
    `FCT_ASSERT_IMP(a_item_done, start && !busy, ##LATENCY done, "item lost in the chain")

    // no result without an item accepted the fixed latency before
    `FCT_ASSERT_IMP(a_no_extra, done, $past(start && !busy, LATENCY), "result with no item")

    // verdict is quiet between results
    `FCT_ASSERT_IMP(a_res_quiet, !done, !inside_res, "inside_res set without done")

    // the chain never refuses an item
    `FCT_ASSERT(a_never_busy, !busy, "busy raised")

endmodule

bind frustum_culling_test fct_checker #(
    .NUM_PLANES (NUM_PLANES)
) u_fct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .inside_res (inside_res)
);

// ----- tb/frustum_culling_test_tb.sv -----
`timescale 1ns / 100ps

module frustum_culling_test_tb;
    import fct_pkg::*;

    // plane count of the instance, also honored by the predictor
    localparam int unsigned N_PLANES = NUM_PLANES_DEF;

    // the result passes the entry register plus two registers in each plane cell
    localparam int PIPE_LATENCY = 1 + 2 * N_PLANES;

    // cycles with no item accepted and no result before the run is declared hung
    localparam int WATCHDOG_CYCLES = 2000;

    // 1.0 in Q2.14, also the scale of d and of the sphere radius
    localparam longint Q14_ONE = longint'(1) << FRAC_BITS;

    // plane register map
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
    // indexes with no register behind them, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI     = 3'd7;

    // handy Q2.14 / integer values for building planes
    localparam shortint FIX_ONE     = 16'sh4000;
    localparam shortint FIX_NEG_ONE = -16'sh4000;
    localparam shortint S16_MAX     = 16'sh7fff;
    localparam shortint S16_MIN     = -16'sh8000;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                command;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic [RADIUS_W-1:0]       radius;
    logic                      done;
    logic                      inside_res;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // predictor's copy of the plane registers
    logic [CFG_DATA_W-1:0] plane_q [MAX_PLANES];
    // staging set for the next load of all six planes
    logic [CFG_DATA_W-1:0] plane_set [MAX_PLANES];

    // expected inside flags, oldest first
    logic inside_q [$];
    logic expected_inside;

    int err_count;
    int stall_cycles;

    frustum_culling_test #(
        .NUM_PLANES (N_PLANES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .ax         (ax),
        .ay         (ay),
        .az         (az),
        .bx         (bx),
        .by         (by),
        .bz         (bz),
        .radius     (radius),
        .done       (done),
        .inside_res (inside_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // signed distance of a point from plane k, exact, in Q.14
    function automatic longint plane_dist(int k, longint x, longint y, longint z);
        logic [CFG_DATA_W-1:0] p;
        p = plane_q[k];
        return longint'($signed(p[15:0])) * x + longint'($signed(p[31:16])) * y
             + longint'($signed(p[47:32])) * z + longint'($signed(p[63:48])) * Q14_ONE;
    endfunction

    // true when no plane puts the point below minus the margin
    function automatic logic clears_planes(longint x, longint y, longint z, longint margin);
        for (int k = 0; k < N_PLANES; k++)
        begin
            if (plane_dist(k, x, y, z) < -margin)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic cull_inside(cmd_t c, shortint x0, shortint y0, shortint z0,
                                         shortint x1, shortint y1, shortint z1,
                                         logic [RADIUS_W-1:0] rad);
        logic ok;
        int   corner;
        ok = 1'b0;
        case (c)
            CMD_POINT:  ok = clears_planes(x0, y0, z0, 0);
            CMD_SPHERE: ok = clears_planes(x0, y0, z0, longint'(rad) * Q14_ONE);
            CMD_BOX:
            begin
                // corners are every mix of the given bounds, reversed or not
                ok = 1'b1;
                for (corner = 0; corner < 8; corner++)
                    ok &= clears_planes(corner[0] ? x1 : x0, corner[1] ? y1 : y0,
                                        corner[2] ? z1 : z0, 0);
            end
            default:    ok = 1'b0;
        endcase
        return ok;
    endfunction

    // ------------------------------------------------------------------
    // result checker and watchdog
    // ------------------------------------------------------------------

    // done is a one-cycle strobe, so every edge with done high is a result
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (inside_q.size() == 0)
            begin
                $error("inside_res: no item outstanding, actual %0b", inside_res);
                err_count++;
            end
            else
            begin
                expected_inside = inside_q.pop_front();
                if (inside_res !== expected_inside)
                begin
                    $error("inside_res mismatch: expected %0b actual %0b",
                           expected_inside, inside_res);
                    err_count++;
                end
            end
        end
    end

    // counts edges where neither an item nor a result moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------

    function automatic logic [CFG_DATA_W-1:0] make_plane(shortint nx, shortint ny,
                                                         shortint nz, shortint d);
        return {d, nz, ny, nx};
    endfunction

    // start stays high after acceptance so back-to-back items need no toggle
    task automatic send_item(cmd_t c, shortint x0, shortint y0, shortint z0,
                             shortint x1, shortint y1, shortint z1,
                             logic [RADIUS_W-1:0] rad);
        start   <= 1'b1;
        command <= c;
        ax      <= x0;
        ay      <= y0;
        az      <= z0;
        bx      <= x1;
        by      <= y1;
        bz      <= z1;
        radius  <= rad;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        inside_q.push_back(cull_inside(c, x0, y0, z0, x1, y1, z1, rad));
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random idle burst about a quarter of the time, when enabled
    task automatic maybe_idle(bit enabled);
        if (enabled && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 15));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
    endtask

    // write enable stays high across consecutive writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < MAX_PLANES)
            plane_q[idx] = data;
    endtask

    // loads plane_set into all six registers, only ever called while drained
    task automatic load_plane_set();
        write_reg(REG_PLANE_LEFT,   plane_set[REG_PLANE_LEFT]);
        write_reg(REG_PLANE_RIGHT,  plane_set[REG_PLANE_RIGHT]);
        write_reg(REG_PLANE_BOTTOM, plane_set[REG_PLANE_BOTTOM]);
        write_reg(REG_PLANE_TOP,    plane_set[REG_PLANE_TOP]);
        write_reg(REG_PLANE_NEAR,   plane_set[REG_PLANE_NEAR]);
        write_reg(REG_PLANE_FAR,    plane_set[REG_PLANE_FAR]);
        cfg_we <= 1'b0;
    endtask

    // span 0 means the full signed 16-bit range
    function automatic shortint rand_coord(int span);
        if (span == 0)
            return shortint'($urandom);
        return shortint'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // second box bound near the first, on either side, so boxes often fit
    function automatic shortint box_partner(shortint lo, int span);
        int ext;
        if (span == 0)
            return shortint'($urandom);
        ext = $urandom_range(0, span / 2);
        return shortint'($urandom_range(0, 3) == 0 ? int'(lo) - ext : int'(lo) + ext);
    endfunction

    task automatic send_random_item();
        cmd_t    c;
        int      span;
        shortint x0, y0, z0;
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 500;
            2:       span = 4000;
            default: span = 16000;
        endcase
        if ($urandom_range(0, 9) == 0)
            c = CMD_NONE;
        else
            c = cmd_t'(2'($urandom_range(0, 2)));
        x0 = rand_coord(span);
        y0 = rand_coord(span);
        z0 = rand_coord(span);
        send_item(c, x0, y0, z0, box_partner(x0, span), box_partner(y0, span),
                  box_partner(z0, span),
                  ($urandom_range(0, 1) != 0) ? RADIUS_W'($urandom)
                                              : RADIUS_W'($urandom_range(0, 4000)));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // planes still at reset: every distance is zero, so only the unused
    // selector reports outside
    task automatic test_reset_planes();
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
        maybe_idle(1);
        send_item(CMD_POINT, S16_MIN, S16_MAX, S16_MIN, 0, 0, 0, 0);
        send_item(CMD_SPHERE, S16_MAX, S16_MIN, S16_MAX, 0, 0, 0, '1);
        maybe_idle(1);
        send_item(CMD_BOX, S16_MAX, S16_MAX, S16_MAX, S16_MIN, S16_MIN, S16_MIN, 0);
        send_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // cube of half-size 1000 around the origin, boundaries hit exactly
    task automatic test_cube_frustum();
        drain_results();
        plane_set[REG_PLANE_LEFT]   = make_plane(FIX_ONE, 0, 0, 1000);
        plane_set[REG_PLANE_RIGHT]  = make_plane(FIX_NEG_ONE, 0, 0, 1000);
        plane_set[REG_PLANE_BOTTOM] = make_plane(0, FIX_ONE, 0, 1000);
        plane_set[REG_PLANE_TOP]    = make_plane(0, FIX_NEG_ONE, 0, 1000);
        plane_set[REG_PLANE_NEAR]   = make_plane(0, 0, FIX_ONE, 1000);
        plane_set[REG_PLANE_FAR]    = make_plane(0, 0, FIX_NEG_ONE, 1000);
        load_plane_set();
        // out-of-range indexes must not disturb the planes just loaded
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, make_plane(S16_MIN, S16_MIN, S16_MIN, S16_MIN));
        cfg_we <= 1'b0;

        send_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 1000, 0, 0, 0, 0, 0, 0);             // on the plane
        maybe_idle(1);
        send_item(CMD_POINT, 1001, 0, 0, 0, 0, 0, 0);             // just outside
        send_item(CMD_POINT, -1000, -1000, -1000, 0, 0, 0, 0);
        send_item(CMD_SPHERE, 1500, 0, 0, 0, 0, 0, 500);          // touching
        maybe_idle(1);
        send_item(CMD_SPHERE, 1500, 0, 0, 0, 0, 0, 499);          // just apart
        send_item(CMD_SPHERE, S16_MAX, S16_MAX, S16_MAX, 0, 0, 0, '1);
        send_item(CMD_BOX, -1000, -1000, -1000, 1000, 1000, 1000, 0);
        maybe_idle(1);
        send_item(CMD_BOX, -1000, -1000, -1000, 1000, 1001, 1000, 0);
        send_item(CMD_BOX, 1000, 1000, 1000, -1000, -1000, -1000, 0); // reversed
        send_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // every plane field pinned at its negative, then positive, extreme
    task automatic test_extreme_planes();
        for (int pass = 0; pass < 2; pass++)
        begin
            drain_results();
            for (int k = 0; k < MAX_PLANES; k++)
                plane_set[k] = pass == 0 ? make_plane(S16_MIN, S16_MIN, S16_MIN, S16_MIN)
                                         : make_plane(S16_MAX, S16_MAX, S16_MAX, S16_MAX);
            load_plane_set();
            send_item(CMD_POINT, S16_MAX, S16_MAX, S16_MAX, 0, 0, 0, 0);
            send_item(CMD_POINT, S16_MIN, S16_MIN, S16_MIN, 0, 0, 0, 0);
            maybe_idle(1);
            send_item(CMD_SPHERE, S16_MIN, S16_MIN, S16_MIN, 0, 0, 0, '1);
            send_item(CMD_BOX, S16_MIN, S16_MIN, S16_MIN, S16_MAX, S16_MAX, S16_MAX, 0);
        end
    endtask

    // several plane settings, each drained before the next load;
    // the last phase runs without idling
    task automatic test_random_phases();
        int kind;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_results();
            for (int k = 0; k < MAX_PLANES; k++)
            begin
                kind = phase == 0 ? 0 : (phase == 2 ? 1 : 2);
                if (phase == 4 && $urandom_range(0, 2) == 0)
                    kind = 3;
                case (kind)
                    0:       plane_set[k] = {$urandom, $urandom};
                    1:       plane_set[k] = make_plane(
                                 $urandom_range(0, 1) ? S16_MIN : S16_MAX,
                                 $urandom_range(0, 1) ? S16_MIN : shortint'($urandom),
                                 $urandom_range(0, 1) ? S16_MAX : shortint'(0),
                                 $urandom_range(0, 1) ? S16_MIN : S16_MAX);
                    // normal components within -1.0 to 1.0 in Q2.14, d of 0 to 12000 keeps the origin inside
                    2:       plane_set[k] = make_plane(
                                 shortint'(int'($urandom_range(0, 32768)) - 16384),
                                 shortint'(int'($urandom_range(0, 32768)) - 16384),
                                 shortint'(int'($urandom_range(0, 32768)) - 16384),
                                 shortint'($urandom_range(0, 12000)));
                    default: plane_set[k] = '0;
                endcase
            end
            load_plane_set();
            for (int n = 0; n < 70; n++)
            begin
                send_random_item();
                maybe_idle(phase != 5);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_POINT;
        ax           = '0;
        ay           = '0;
        az           = '0;
        bx           = '0;
        by           = '0;
        bz           = '0;
        radius       = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        err_count    = 0;
        stall_cycles = 0;
        for (int k = 0; k < MAX_PLANES; k++)
            plane_q[k] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_planes();
        test_cube_frustum();
        test_extreme_planes();
        test_random_phases();

        // all items in, now wait out the pipeline and look for strays
        drain_results();
        repeat (2 * PIPE_LATENCY + 4) @(posedge clk);
        if (inside_q.size() != 0)
        begin
            $error("inside_res: %0d results never arrived", inside_q.size());
            err_count++;
        end

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
